// ===== design/capture_tachometer_ema_defines.svh =====
// Assertion macros shared by the tachometer checker.
// The macros expect clk_i and rst_ni to exist in the scope that uses them.
`ifndef CAPTURE_TACHOMETER_EMA_DEFINES_SVH
`define CAPTURE_TACHOMETER_EMA_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tachometer check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tachometer check failed");

`endif

// ===== design/cte_pkg.sv =====
// Shared types, codes and constants of the capture tachometer.
// Used by every module of the block but cte_div; depends on nothing.
`default_nettype none

package cte_pkg;

  localparam int unsigned TICK_HZ_DEF = 1000000;

  localparam int unsigned CAP_W    = 16;
  localparam int unsigned OVF_W    = 32;
  localparam int unsigned PPR_W    = 8;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned RATE_W   = 34;
  localparam int unsigned DEN_W    = OVF_W + PPR_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 72;

  // Ticks per minute in Q.8, per hertz of the capture tick rate.
  localparam longint unsigned NUM_PER_HZ = 64'd15360;

  localparam logic [RATE_W-1:0]  RATE_MAX      = {RATE_W{1'b1}};
  localparam logic [PPR_W-1:0]   PPR_RESET     = 8'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd13107;
  localparam logic [ALPHA_W:0]   ALPHA_ONE     = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA = 1'b1;

  localparam logic ACT_OVERFLOW = 1'b0;
  localparam logic ACT_CAPTURE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PRIMED   = 2'd0,
    KIND_MEASURED = 2'd1,
    KIND_ZERO     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SAT,
    ST_FILT_A,
    ST_FILT_B,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic ovf_inc;
    logic load_in;
    logic calc;
    logic div_start;
    logic sat;
    logic filt_a;
    logic filt_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic delta_zero;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/cte_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cte_pkg only through the instantiating datapath's widths.
`default_nettype none

module cte_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic                  done_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the difference fits DEN_W bits.
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/cte_dp.sv =====
// Datapath of the tachometer: counters, interval, rate division and filter.
// Depends on cte_pkg and cte_div; driven by commands from cte_ctrl.
`default_nettype none

module cte_dp #(
  parameter int unsigned TICK_HZ = cte_pkg::TICK_HZ_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cte_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cte_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [cte_pkg::CAP_W-1:0]        cap_i,
  input  wire logic                             late_i,
  input  wire cte_pkg::cmd_t                    cmd_i,
  output cte_pkg::stat_t                        stat_o,
  output cte_pkg::kind_e                        out_kind_o,
  output logic      [cte_pkg::RATE_W-1:0]       out_raw_o,
  output logic      [cte_pkg::RATE_W-1:0]       out_smooth_o
);
  import cte_pkg::*;

  localparam longint unsigned NUM_VAL = 64'(TICK_HZ) * NUM_PER_HZ;
  localparam int unsigned NUM_W = $clog2(NUM_VAL + 1);
  localparam int unsigned EXT_W = (NUM_W > RATE_W) ? NUM_W : RATE_W;
  localparam int unsigned PA_W  = ALPHA_W + RATE_W;
  localparam int unsigned PB_W  = ALPHA_W + 1 + RATE_W;
  localparam int unsigned SUM_W = PB_W + 1;

  logic [PPR_W-1:0]   ppr_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [OVF_W-1:0]   ovf_q;
  logic [OVF_W-1:0]   prev_q;
  logic               first_q;
  logic [RATE_W-1:0]  smooth_q;
  logic [CAP_W-1:0]   cap_q;
  logic               late_q;
  logic [DEN_W-1:0]   den_q;
  logic [RATE_W-1:0]  raw_q;
  kind_e              kind_q;
  logic [PA_W-1:0]    prod_a_q;
  logic [PB_W-1:0]    prod_b_q;
  kind_e              out_kind_q;
  logic [RATE_W-1:0]  out_raw_q;
  logic [RATE_W-1:0]  out_smooth_q;

  logic [OVF_W-1:0]   ovf_sum;
  logic [OVF_W-1:0]   absolute;
  logic [OVF_W-1:0]   delta;
  logic [PPR_W-1:0]   ppr_eff;
  logic [NUM_W-1:0]   quo;
  logic               div_done;
  logic [EXT_W-1:0]   quo_ext;
  logic [RATE_W-1:0]  rate_sat;
  logic [ALPHA_W:0]   beta;
  logic [SUM_W-1:0]   filt_sum;

  assign ovf_sum  = ovf_q + OVF_W'(late_q);
  assign absolute = {ovf_sum[OVF_W-CAP_W-1:0], cap_q};
  assign delta    = absolute - prev_q;
  assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

  assign quo_ext  = EXT_W'(quo);
  assign rate_sat = (quo_ext > EXT_W'(RATE_MAX)) ? RATE_MAX : quo_ext[RATE_W-1:0];
  assign beta     = ALPHA_ONE - {1'b0, alpha_q};
  assign filt_sum = SUM_W'(prod_a_q) + SUM_W'(prod_b_q);

  cte_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (NUM_W'(NUM_VAL)),
    .den_i  (den_q),
    .quo_o  (quo),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q    <= PPR_RESET;
      alpha_q  <= ALPHA_RESET;
      ovf_q    <= '0;
      prev_q   <= '0;
      first_q  <= 1'b1;
      smooth_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IDX_PPR) begin
        ppr_q <= cfg_data_i[PPR_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_IDX_ALPHA) begin
        alpha_q <= cfg_data_i[ALPHA_W-1:0];
      end
      if (cmd_i.ovf_inc) begin
        ovf_q <= ovf_q + OVF_W'(1);
      end
      if (cmd_i.calc) begin
        prev_q <= absolute;
        if (first_q) begin
          first_q  <= 1'b0;
          smooth_q <= '0;
        end
      end
      // The sum never exceeds 2^16 times the larger rate, so the shift fits the rate width.
      if (cmd_i.filt_b) begin
        smooth_q <= filt_sum[RATE_W+ALPHA_W-1:ALPHA_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cap_q  <= cap_i;
      late_q <= late_i;
    end
    if (cmd_i.calc) begin
      den_q <= {{PPR_W{1'b0}}, delta} * {{OVF_W{1'b0}}, ppr_eff};
      raw_q <= '0;
      if (first_q) begin
        kind_q <= KIND_PRIMED;
      end else if (delta == '0) begin
        kind_q <= KIND_ZERO;
      end else begin
        kind_q <= KIND_MEASURED;
      end
    end
    if (cmd_i.sat) begin
      raw_q <= rate_sat;
    end
    if (cmd_i.filt_a) begin
      prod_a_q <= alpha_q * raw_q;
      prod_b_q <= beta * smooth_q;
    end
    if (cmd_i.out_load) begin
      out_kind_q   <= kind_q;
      out_raw_q    <= raw_q;
      out_smooth_q <= smooth_q;
    end
  end

  assign stat_o.first      = first_q;
  assign stat_o.delta_zero = (delta == '0);
  assign stat_o.div_done   = div_done;

  assign out_kind_o   = out_kind_q;
  assign out_raw_o    = out_raw_q;
  assign out_smooth_o = out_smooth_q;

endmodule

`default_nettype wire

// ===== design/cte_ctrl.sv =====
// Controller of the tachometer: sequences one event through the datapath
// and owns the stream handshakes. Depends on cte_pkg.
`default_nettype none

module cte_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire cte_pkg::stat_t stat_i,
  output cte_pkg::cmd_t       cmd_o
);
  import cte_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_action_i == ACT_CAPTURE) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (stat_i.first || stat_i.delta_zero) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT:    state_d = ST_FILT_A;
      ST_FILT_A: state_d = ST_FILT_B;
      ST_FILT_B: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_fire;
        cmd_o.ovf_inc = in_fire && (in_action_i == ACT_OVERFLOW);
      end
      ST_CALC:      cmd_o.calc      = 1'b1;
      ST_DIV_START: cmd_o.div_start = 1'b1;
      ST_DIV_WAIT:  cmd_o           = '0;
      ST_SAT:       cmd_o.sat       = 1'b1;
      ST_FILT_A:    cmd_o.filt_a    = 1'b1;
      ST_FILT_B:    cmd_o.filt_b    = 1'b1;
      ST_EMIT: begin
        cmd_o.out_load = out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/capture_tachometer_ema.sv =====
// Capture tachometer with exponential rate filter.
// Input stream: one transaction per timer event. tuser is the action (overflow or
// capture); tdata carries the captured count and the late-overflow flag.
// Output stream: one transaction per capture event, none per overflow. tuser is
// the status; tdata carries the instantaneous and the smoothed rate, both Q26.8.
// Configuration: write pulses_per_rev (index 0) and filter_alpha (index 1) while idle.
// An overflow transaction is absorbed in the idle state. A first capture or a zero
// interval goes from the calculation state straight to emit. A measured capture
// runs the bit-serial divider, which produces one quotient bit per cycle, and then
// passes through ST_SAT, ST_FILT_A and ST_FILT_B; the quotient has NUM_W bits, the width of
// TICK_HZ * 15360. Input is taken only while no capture is in flight.
// The result sits in an output register, so the next transaction is accepted
// while it waits; a stalled receiver holds the register and, once a second
// result is ready, the block waits before taking more input.
// Reset sets both registers to their defaults, clears the counters and the filter,
// and marks the next capture as the first one.
`default_nettype none

module capture_tachometer_ema #(
  parameter int unsigned TICK_HZ = cte_pkg::TICK_HZ_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cte_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cte_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] capture_count, [16] late_overflow, [23:17] zero
  input  wire logic [cte_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] action
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [33:0] rpm_raw, [67:34] rpm_smoothed, [71:68] zero
  output logic      [cte_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic      [1:0]                       m_axis_tuser
);
  import cte_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  kind_e             out_kind;
  logic [RATE_W-1:0] out_raw;
  logic [RATE_W-1:0] out_smooth;

  cte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_action_i(s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cte_dp #(
    .TICK_HZ(TICK_HZ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cap_i       (s_axis_tdata[CAP_W-1:0]),
    .late_i      (s_axis_tdata[CAP_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_kind_o  (out_kind),
    .out_raw_o   (out_raw),
    .out_smooth_o(out_smooth)
  );

  assign m_axis_tdata = {{(M_TDATA_W - 2 * RATE_W){1'b0}}, out_smooth, out_raw};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

// ===== design/cte_checker.sv =====
// Port-level checker for the capture tachometer, bound to the top level.
// Depends on cte_pkg and capture_tachometer_ema_defines.svh.
`default_nettype none
`include "capture_tachometer_ema_defines.svh"

module cte_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [cte_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [1:0]                     m_axis_tuser
);
  import cte_pkg::*;

  // A stalled result keeps its content.
  `CTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only a measured capture reports a nonzero instantaneous rate.
  `CTE_ASSERT_SAME(a_raw_zero, m_axis_tvalid && m_axis_tuser != KIND_MEASURED, m_axis_tdata[RATE_W-1:0] == '0)

  // The first capture restarts the filter from zero.
  `CTE_ASSERT_SAME(a_primed_clear, m_axis_tvalid && m_axis_tuser == KIND_PRIMED, m_axis_tdata[2*RATE_W-1:RATE_W] == '0)

  // An overflow transaction never brings out a result of its own.
  `CTE_ASSERT_NEXT(a_ovf_silent, s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_OVERFLOW && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind capture_tachometer_ema cte_checker u_cte_checker (.*);

`default_nettype wire

// ===== test/capture_tachometer_ema_checker.sv =====
// Checker for the capture tachometer: watches the config port and both streams,
// predicts each reading from accepted timer events and compares it on output.
// Depends on cte_pkg for widths, register indexes, actions and status kinds.
module capture_tachometer_ema_checker #(
  parameter int unsigned TICK_HZ = cte_pkg::TICK_HZ_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cte_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cte_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [cte_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [cte_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic [1:0]                       m_axis_tuser,
  output int                               mismatches_o,
  output int                               pending_o
);
  import cte_pkg::*;

  // Ticks per minute in Q.8.
  localparam logic [63:0] RPM_NUMERATOR = 64'(TICK_HZ) * 64'd15360;

  typedef struct packed {
    kind_e              status;
    logic [RATE_W-1:0]  rpm_raw;
    logic [RATE_W-1:0]  rpm_smoothed;
  } reading_t;

  reading_t readings_due[$];

  logic [PPR_W-1:0]   ppr;
  logic [ALPHA_W-1:0] alpha;
  logic [31:0]        overflow_count;
  logic [31:0]        last_abs;
  logic               awaiting_first;
  logic [RATE_W-1:0]  smoothed;

  function automatic logic [RATE_W-1:0] rate_of_interval(input logic [31:0] ticks);
    logic [63:0] den;
    logic [63:0] q;
    den = 64'(ticks) * 64'((ppr == '0) ? 8'd1 : ppr);
    q = RPM_NUMERATOR / den;
    return (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
  endfunction

  task automatic take_event(input logic action, input logic [15:0] cap, input logic late);
    logic [31:0] abs_ticks;
    logic [31:0] interval;
    logic [63:0] blend;
    reading_t    r;
    if (action == ACT_OVERFLOW) begin
      overflow_count = overflow_count + 32'd1;
      return;
    end
    abs_ticks = ((overflow_count + 32'(late)) << 16) + 32'(cap);
    r.rpm_raw = '0;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      smoothed = '0;
      r.status = KIND_PRIMED;
    end else begin
      interval = abs_ticks - last_abs;
      if (interval == 32'd0) begin
        r.status = KIND_ZERO;
      end else begin
        r.rpm_raw = rate_of_interval(interval);
        blend = 64'(alpha) * 64'(r.rpm_raw) + (64'd65536 - 64'(alpha)) * 64'(smoothed);
        smoothed = blend[RATE_W+15:16];
        r.status = KIND_MEASURED;
      end
    end
    last_abs = abs_ticks;
    r.rpm_smoothed = smoothed;
    readings_due.push_back(r);
  endtask

  task automatic check_reading();
    reading_t          exp_r;
    logic [RATE_W-1:0] act_raw;
    logic [RATE_W-1:0] act_smooth;
    act_raw = m_axis_tdata[RATE_W-1:0];
    act_smooth = m_axis_tdata[2*RATE_W-1:RATE_W];
    if (readings_due.size() == 0) begin
      if (mismatches_o < 10)
        $display("unexpected reading: status %0d raw %0d smoothed %0d",
                 m_axis_tuser, act_raw, act_smooth);
      mismatches_o++;
      return;
    end
    exp_r = readings_due.pop_front();
    if (m_axis_tuser !== exp_r.status || act_raw !== exp_r.rpm_raw ||
        act_smooth !== exp_r.rpm_smoothed) begin
      if (mismatches_o < 10)
        $display("reading mismatch: status %0d/%0d raw %0d/%0d smoothed %0d/%0d (exp/act)",
                 exp_r.status, m_axis_tuser, exp_r.rpm_raw, act_raw,
                 exp_r.rpm_smoothed, act_smooth);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr = PPR_RESET;
      alpha = ALPHA_RESET;
      overflow_count = '0;
      last_abs = '0;
      awaiting_first = 1'b1;
      smoothed = '0;
      mismatches_o = 0;
      readings_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_PPR) ppr = cfg_data_i[PPR_W-1:0];
        else if (cfg_idx_i == CFG_IDX_ALPHA) alpha = cfg_data_i[ALPHA_W-1:0];
      end
      // Outputs first, so a reading is never matched against its own input.
      if (m_axis_tvalid && m_axis_tready) check_reading();
      if (s_axis_tvalid && s_axis_tready)
        take_event(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16]);
    end
    pending_o = readings_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the tachometer testbench: clock, reset, directed and random timer events,
// register programming between phases, a randomly stalling receiver and the verdict.
// Depends on cte_pkg, capture_tachometer_ema and capture_tachometer_ema_checker.
module testbench;
  import cte_pkg::*;

  localparam int SETTLE_CYCLES = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_IDX_PPR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = ACT_OVERFLOW;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [1:0]            m_tuser;
  int                    mismatches;
  int                    pending;
  bit                    calm = 1'b0;
  int                    ready_hold = 0;
  logic [15:0]           last_cap = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  capture_tachometer_ema u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  capture_tachometer_ema_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || !m_tready) begin
      m_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b0;
      ready_hold <= gap_len();
    end
  end

  task automatic send_event(input logic action, input logic [15:0] cap, input logic late);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= {7'd0, late, cap};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (action == ACT_CAPTURE) last_cap = cap;
  endtask

  // Overflow events give no reading, so the block gets extra time after the
  // last reading before it counts as idle.
  task automatic drain_readings();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [PPR_W-1:0] ppr, input logic [ALPHA_W-1:0] alpha);
    logic [7:0] junk;
    junk = $urandom_range(0, 255);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IDX_PPR;
    cfg_data <= {junk, ppr};
    @(posedge clk_i);
    cfg_idx <= CFG_IDX_ALPHA;
    cfg_data <= alpha;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly captures a plausible interval after the last one, plus overflows,
  // late-overflow captures, repeated counts and arbitrary counts.
  task automatic random_event();
    int          r;
    logic [15:0] stride;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       stride = $urandom_range(1, 16);
      1:       stride = $urandom_range(17, 3000);
      default: stride = $urandom_range(3001, 65535);
    endcase
    if (r < 30) send_event(ACT_OVERFLOW, 16'($urandom), 1'($urandom));
    else if (r < 70) send_event(ACT_CAPTURE, last_cap + stride, 1'b0);
    else if (r < 80) send_event(ACT_CAPTURE, last_cap + stride, 1'b1);
    else if (r < 88) send_event(ACT_CAPTURE, last_cap, 1'b0);
    else send_event(ACT_CAPTURE, 16'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [PPR_W-1:0]   ppr;
    logic [ALPHA_W-1:0] alpha;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: priming, zero interval, fastest rate, wrapping intervals.
    send_event(ACT_OVERFLOW, 16'hFFFF, 1'b1);
    send_event(ACT_CAPTURE, 16'd100, 1'b0);
    send_event(ACT_CAPTURE, 16'd100, 1'b0);
    send_event(ACT_CAPTURE, 16'd101, 1'b0);
    send_event(ACT_CAPTURE, 16'd0, 1'b1);
    send_event(ACT_CAPTURE, 16'hFFFF, 1'b0);
    send_event(ACT_OVERFLOW, 16'd0, 1'b0);
    send_event(ACT_OVERFLOW, 16'd0, 1'b0);
    send_event(ACT_CAPTURE, 16'hFFFF, 1'b1);
    send_event(ACT_CAPTURE, 16'd0, 1'b0);
    // A late-overflow capture followed by the overflow itself and the same count.
    send_event(ACT_CAPTURE, 16'h1234, 1'b1);
    send_event(ACT_OVERFLOW, 16'd0, 1'b0);
    send_event(ACT_CAPTURE, 16'h1234, 1'b0);

    // Zero pulses per revolution acts as one; full filter weight.
    drain_readings();
    program_regs(8'd0, 16'hFFFF);
    send_event(ACT_CAPTURE, 16'h1235, 1'b0);
    send_event(ACT_CAPTURE, 16'h1236, 1'b0);

    // Most pulses per revolution; filter frozen.
    drain_readings();
    program_regs(8'd255, 16'd0);
    send_event(ACT_CAPTURE, 16'h1237, 1'b0);
    send_event(ACT_CAPTURE, 16'h1236, 1'b0);
    send_event(ACT_CAPTURE, 16'hFFFF, 1'b1);
    send_event(ACT_CAPTURE, 16'd1, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin ppr = 8'd1;   alpha = 16'hFFFF; end
        1:       begin ppr = 8'd255; alpha = 16'd1; end
        2:       begin ppr = 8'd0;   alpha = ALPHA_RESET; end
        3:       begin ppr = 8'd1;   alpha = 16'($urandom); end
        default: begin ppr = 8'($urandom); alpha = 16'($urandom); end
      endcase
      drain_readings();
      program_regs(ppr, alpha);
      for (int i = 0; i < 175; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        random_event();
      end
    end
    calm = 1'b0;

    drain_readings();
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/cte_pkg.sv
design/cte_div.sv
design/cte_dp.sv
design/cte_ctrl.sv
design/capture_tachometer_ema.sv
design/cte_checker.sv
test/capture_tachometer_ema_checker.sv
test/testbench.sv
